>>> design/sfmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmq_pkg
// Shared types and codes for the symbol frequency min-queue.
// ----------------------------------------------------------------------------
package sfmq_pkg;

  localparam int HIST_AW_MAX = 8;  // histogram address width at the largest alphabet

  typedef enum logic [1:0] {
    ACT_COUNT  = 2'd0,
    ACT_BUILD  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CNT_RD,
    S_CNT_WR,
    S_BUILD,
    S_INSERT,
    S_RM_SCAN,
    S_RM_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]  node;
    logic [31:0] weight;
  } entry_t;

  // histogram port controls
  typedef struct packed {
    logic                   rd_en;
    logic [HIST_AW_MAX-1:0] rd_addr;
    logic                   wr_en;
    logic [HIST_AW_MAX-1:0] wr_addr;
    logic [31:0]            wr_data;
    logic                   clear;
  } hist_ctl_t;

endpackage

>>> design/symbol_frequency_min_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symbol_frequency_min_queue_core
// Huffman front end: symbol histogram plus a (node, count) list used as a
// minimum-priority queue with in-order compaction on removal.
// ----------------------------------------------------------------------------
// Throughput: one item at a time, plus any wait on m_tready; the next item is
//   taken in the cycle after its result loads. Ports walk one entry per cycle.
// Count ignores symbol 0 and symbols at or above ALPHABET.
// Reset: list empty, histogram all zero at once through per-bin valid bits;
//   no clearing pass, the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module symbol_frequency_min_queue_core #(
  parameter int ALPHABET   = 128,
  parameter int LIST_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // symbol[6:0], node_id[14:7], weight[46:15], zero[47]
  input  logic [1:0]  s_tuser,   // action[1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_node[7:0], out_weight[39:8], entries[48:40], zero
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int HAW = $clog2(ALPHABET);        // histogram address bits
  localparam int HBW = HAW + 1;                 // bin pointer, reaches ALPHABET
  localparam int LAW = $clog2(LIST_DEPTH);      // list address bits
  localparam int CW  = $clog2(LIST_DEPTH + 1);  // entry count bits

  localparam logic [HBW-1:0] ALPHA_END = HBW'(ALPHABET);
  localparam logic [CW-1:0]  LIST_FULL = CW'(LIST_DEPTH);

  // --------------------------------------------------------------------------
  // Input unpack
  // --------------------------------------------------------------------------
  logic                  s_fire;
  sfmq_pkg::action_t     in_action;
  logic [6:0]            in_symbol;
  logic [7:0]            in_node;
  logic [31:0]           in_weight;

  assign s_fire    = s_tvalid && s_tready;
  assign in_action = sfmq_pkg::action_t'(s_tuser);
  assign in_symbol = s_tdata[6:0];
  assign in_node   = s_tdata[14:7];
  assign in_weight = s_tdata[46:15];

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  sfmq_pkg::state_t  state, state_next;
  logic [CW-1:0]     count;       // entries in list
  logic [6:0]        sym_q;
  sfmq_pkg::entry_t  ins_q;       // entry held for insert
  sfmq_pkg::status_t res_status;
  sfmq_pkg::entry_t  res_entry;   // removed entry, zero otherwise

  // histogram walk (build)
  logic [HBW-1:0]    bptr;
  logic              hv;          // read data from bin hidx arrives this cycle
  logic [HAW-1:0]    hidx;

  // list walk (remove scan and shift)
  logic [CW-1:0]     lptr;
  logic              lv;
  logic [LAW-1:0]    lidx;
  sfmq_pkg::entry_t  best;
  logic [LAW-1:0]    bidx;

  // --------------------------------------------------------------------------
  // Histogram store
  // --------------------------------------------------------------------------
  sfmq_pkg::hist_ctl_t hctl;
  logic [31:0]         hrd;

  sfmq_hist #(
    .ALPHABET (ALPHABET)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .ctl     (hctl),
    .rd_data (hrd)
  );

  // --------------------------------------------------------------------------
  // List RAM: entry_t words, one write and one registered read per cycle
  // --------------------------------------------------------------------------
  sfmq_pkg::entry_t lmem [LIST_DEPTH];
  logic             l_we;
  logic [LAW-1:0]   l_waddr;
  sfmq_pkg::entry_t l_wdata;
  logic             l_re;
  logic [LAW-1:0]   l_raddr;
  sfmq_pkg::entry_t l_rdata;

  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[l_waddr] <= l_wdata;
    end
    if (l_re) begin
      l_rdata <= lmem[l_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and port controls
  // --------------------------------------------------------------------------
  logic hist_issue;
  logic list_issue;
  logic list_room;
  logic sym_live;
  logic out_free;
  logic push_bin;

  assign hist_issue = (state == sfmq_pkg::S_BUILD) && (bptr < ALPHA_END);
  assign list_issue = ((state == sfmq_pkg::S_RM_SCAN) || (state == sfmq_pkg::S_RM_SHIFT))
                      && (lptr < count);
  assign list_room  = count < LIST_FULL;
  assign sym_live   = (in_symbol != 7'd0) && (9'(in_symbol) < 9'(ALPHABET));
  assign out_free   = !m_tvalid || m_tready;
  assign push_bin   = (state == sfmq_pkg::S_BUILD) && hv && (hrd != 32'd0);

  always_comb begin
    state_next   = state;
    hctl         = '0;
    l_we         = 1'b0;
    l_waddr      = count[LAW-1:0];
    l_wdata      = ins_q;
    l_re         = list_issue;
    l_raddr      = lptr[LAW-1:0];
    s_tready     = (state == sfmq_pkg::S_IDLE);

    unique case (state)
      sfmq_pkg::S_IDLE: begin
        if (s_fire) begin
          unique case (in_action)
            sfmq_pkg::ACT_COUNT:  state_next = sym_live ? sfmq_pkg::S_CNT_RD : sfmq_pkg::S_DONE;
            sfmq_pkg::ACT_BUILD:  state_next = sfmq_pkg::S_BUILD;
            sfmq_pkg::ACT_INSERT: state_next = sfmq_pkg::S_INSERT;
            sfmq_pkg::ACT_REMOVE: begin
              state_next = (count == '0) ? sfmq_pkg::S_DONE : sfmq_pkg::S_RM_SCAN;
            end
            default: state_next = sfmq_pkg::S_DONE;
          endcase
        end
      end
      sfmq_pkg::S_CNT_RD: begin
        hctl.rd_en   = 1'b1;
        hctl.rd_addr = 8'(sym_q);
        state_next   = sfmq_pkg::S_CNT_WR;
      end
      sfmq_pkg::S_CNT_WR: begin
        // saturating increment; a full bin is left alone
        hctl.wr_en   = (hrd != 32'hFFFF_FFFF);
        hctl.wr_addr = 8'(sym_q);
        hctl.wr_data = hrd + 32'd1;
        state_next   = sfmq_pkg::S_DONE;
      end
      sfmq_pkg::S_BUILD: begin
        hctl.rd_en   = hist_issue;
        hctl.rd_addr = 8'(bptr[HAW-1:0]);
        l_we         = push_bin && list_room;
        l_wdata.node   = 8'(hidx);
        l_wdata.weight = hrd;
        if (!hist_issue && !hv) begin
          hctl.clear = 1'b1;
          state_next = sfmq_pkg::S_DONE;
        end
      end
      sfmq_pkg::S_INSERT: begin
        l_we       = list_room;
        state_next = sfmq_pkg::S_DONE;
      end
      sfmq_pkg::S_RM_SCAN: begin
        if (!list_issue && !lv) begin
          state_next = sfmq_pkg::S_RM_SHIFT;
        end
      end
      sfmq_pkg::S_RM_SHIFT: begin
        // entry at lidx moves up one place
        l_we    = lv;
        l_waddr = lidx - LAW'(1);
        l_wdata = l_rdata;
        if (!list_issue && !lv) begin
          state_next = sfmq_pkg::S_DONE;
        end
      end
      sfmq_pkg::S_DONE: begin
        if (out_free) begin
          state_next = sfmq_pkg::S_IDLE;
        end
      end
      default: state_next = sfmq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfmq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      hv    <= 1'b0;
      lv    <= 1'b0;
    end else begin
      hv <= hist_issue;
      lv <= list_issue;
      if (s_fire && (in_action == sfmq_pkg::ACT_BUILD)) begin
        count <= '0;
      end else if (l_we && (state != sfmq_pkg::S_RM_SHIFT)) begin
        count <= count + CW'(1);
      end else if ((state == sfmq_pkg::S_RM_SHIFT) && !list_issue && !lv) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      sym_q        <= in_symbol;
      ins_q.node   <= in_node;
      ins_q.weight <= in_weight;
      res_entry    <= '0;
      bptr         <= HBW'(1);   // bin 0 is the terminator
      lptr         <= '0;
      if ((in_action == sfmq_pkg::ACT_REMOVE) && (count == '0)) begin
        res_status <= sfmq_pkg::ST_EMPTY;
      end else begin
        res_status <= sfmq_pkg::ST_OK;
      end
    end

    if (hist_issue) begin
      bptr <= bptr + HBW'(1);
      hidx <= bptr[HAW-1:0];
    end
    if (push_bin && !list_room) begin
      res_status <= sfmq_pkg::ST_FULL;
    end
    if ((state == sfmq_pkg::S_INSERT) && !list_room) begin
      res_status <= sfmq_pkg::ST_FULL;
    end

    if (list_issue) begin
      lptr <= lptr + CW'(1);
      lidx <= lptr[LAW-1:0];
    end

    // strict minimum: the earliest of equal counts is kept
    if ((state == sfmq_pkg::S_RM_SCAN) && lv) begin
      if ((lidx == '0) || (l_rdata.weight < best.weight)) begin
        best <= l_rdata;
        bidx <= lidx;
      end
    end
    if ((state == sfmq_pkg::S_RM_SCAN) && !list_issue && !lv) begin
      res_entry <= best;
      lptr      <= CW'(bidx) + CW'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == sfmq_pkg::S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == sfmq_pkg::S_DONE) && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {7'd0, 9'(count), res_entry.weight, res_entry.node};
    end
  end

endmodule

>>> design/sfmq_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfmq_hist
// Histogram store: one write and one registered read port, with a valid bit
// per bin so that reset and a bulk clear take effect at once, with no clearing pass.
// ----------------------------------------------------------------------------
module sfmq_hist #(
  parameter int ALPHABET = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  sfmq_pkg::hist_ctl_t ctl,
  output logic [31:0]         rd_data
);

  localparam int HAW = $clog2(ALPHABET);

  logic [31:0]         mem [ALPHABET];
  logic [ALPHABET-1:0] valid;
  logic [31:0]         rd_q;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr[HAW-1:0]] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[ctl.rd_addr[HAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (ctl.clear) begin
        valid <= '0;
      end else if (ctl.wr_en) begin
        valid[ctl.wr_addr[HAW-1:0]] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld <= valid[ctl.rd_addr[HAW-1:0]];
      end
    end
  end

  // a bin never written since the last clear reads as zero
  assign rd_data = rd_vld ? rd_q : 32'd0;

endmodule
